// File: sv/srr_pkg.sv
`timescale 1ns / 1ps

package srr_pkg;

    // Reorder buffer depth; slots are indexed by the low sequence bits,
    // so this must be a power of two.
    localparam int WINDOW_MAX  = 32;
    localparam int SLOT_AW     = $clog2(WINDOW_MAX);
    localparam int MAX_PAYLOAD = 1456;

    localparam int SEQ_W    = 32;
    localparam int LEN_W    = 11;
    localparam int HANDLE_W = 16;
    localparam int FILE_W   = 16;
    localparam int WIN_W    = 6;
    localparam int SLOT_W   = HANDLE_W + LEN_W;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd10;

    typedef enum logic [1:0] {
        PKT_START = 2'd0,
        PKT_END   = 2'd1,
        PKT_DATA  = 2'd2,
        PKT_ACK   = 2'd3
    } t_pkt_type;

    typedef enum logic [1:0] {
        ACT_ACK     = 2'd0,
        ACT_DELIVER = 2'd1,
        ACT_OPEN    = 2'd2,
        ACT_CLOSE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EMIT2,
        ST_DRAIN,
        ST_ACK
    } t_state;

    // One result item
    typedef struct packed {
        t_action             action;
        logic [SEQ_W-1:0]    ack_seq;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    len;
        logic [FILE_W-1:0]   file_index;
        logic                last;
    } t_result;

    // Slot memory request: one write port, one read port
    typedef struct packed {
        logic               we;
        logic [SLOT_AW-1:0] waddr;
        logic [SLOT_W-1:0]  wdata;
        logic               re;
        logic [SLOT_AW-1:0] raddr;
    } t_ram_req;

endpackage

// File: sv/srr_slot_ram.sv
`timescale 1ns / 1ps

module srr_slot_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 27
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/srr_ctrl.sv
`timescale 1ns / 1ps

module srr_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  srr_pkg::t_pkt_type              i_pkt_type,
    input  logic [srr_pkg::SEQ_W-1:0]       i_seq_num,
    input  logic [srr_pkg::LEN_W-1:0]       i_payload_len,
    input  logic [srr_pkg::HANDLE_W-1:0]    i_payload_handle,
    input  logic                            i_frame_good,
    input  logic [srr_pkg::WIN_W-1:0]       i_window,
    input  logic                            i_out_free,
    output logic                            o_emit,
    output srr_pkg::t_result                o_res,
    output srr_pkg::t_ram_req               o_ram,
    input  logic [srr_pkg::SLOT_W-1:0]      i_ram_rdata
);

    srr_pkg::t_state                 r_state, n_state;
    srr_pkg::t_pkt_type              r_type;
    logic [srr_pkg::SEQ_W-1:0]       r_seq;
    logic [srr_pkg::LEN_W-1:0]       r_len;
    logic [srr_pkg::HANDLE_W-1:0]    r_handle;
    logic                            r_good;

    logic                            r_active, n_active;
    logic [srr_pkg::SEQ_W-1:0]       r_expected, n_expected;
    logic [srr_pkg::SEQ_W-1:0]       r_start_seq, n_start_seq;
    logic [srr_pkg::FILE_W-1:0]      r_conn_count, n_conn_count;
    logic [srr_pkg::WINDOW_MAX-1:0]  r_valid, n_valid;

    logic                            w_accept;
    logic                            w_bad;
    logic [srr_pkg::SEQ_W-1:0]       w_off;
    logic [srr_pkg::SEQ_W-1:0]       w_win;
    logic [srr_pkg::SLOT_AW-1:0]     w_slot;
    logic [srr_pkg::SLOT_AW-1:0]     w_next_slot;
    logic [srr_pkg::SLOT_AW-1:0]     w_drain_next;

    assign o_in_ready = (r_state == srr_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Latch the item on accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_type   <= i_pkt_type;
            r_seq    <= i_seq_num;
            r_len    <= i_payload_len;
            r_handle <= i_payload_handle;
            r_good   <= i_frame_good;
        end
    end

    // Window clamped to 1..WINDOW_MAX
    always_comb begin
        if (i_window == '0) begin
            w_win = srr_pkg::SEQ_W'(1);
        end else if (srr_pkg::SEQ_W'(i_window) > srr_pkg::SEQ_W'(srr_pkg::WINDOW_MAX)) begin
            w_win = srr_pkg::SEQ_W'(srr_pkg::WINDOW_MAX);
        end else begin
            w_win = srr_pkg::SEQ_W'(i_window);
        end
    end

    assign w_bad        = !r_good || (r_len > srr_pkg::LEN_W'(srr_pkg::MAX_PAYLOAD));
    assign w_off        = r_seq - r_expected;
    assign w_slot       = r_seq[srr_pkg::SLOT_AW-1:0];
    assign w_next_slot  = w_slot + srr_pkg::SLOT_AW'(1);
    assign w_drain_next = r_expected[srr_pkg::SLOT_AW-1:0] + srr_pkg::SLOT_AW'(1);

    // State and connection registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= srr_pkg::ST_IDLE;
            r_active     <= 1'b0;
            r_expected   <= '0;
            r_start_seq  <= '0;
            r_conn_count <= '0;
            r_valid      <= '0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_expected   <= n_expected;
            r_start_seq  <= n_start_seq;
            r_conn_count <= n_conn_count;
            r_valid      <= n_valid;
        end
    end

    // Next state, results and slot memory accesses
    always_comb begin
        n_state      = r_state;
        n_active     = r_active;
        n_expected   = r_expected;
        n_start_seq  = r_start_seq;
        n_conn_count = r_conn_count;
        n_valid      = r_valid;
        o_emit       = 1'b0;
        o_res        = '0;
        o_res.action     = srr_pkg::ACT_ACK;
        o_res.file_index = r_conn_count;
        o_ram        = '0;

        unique case (r_state)
            srr_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = srr_pkg::ST_EVAL;
                end
            end

            srr_pkg::ST_EVAL: begin
                priority if (w_bad) begin
                    n_state = srr_pkg::ST_IDLE;
                end else if (!r_active) begin
                    // Open a new connection on start, ignore the rest
                    if (r_type != srr_pkg::PKT_START) begin
                        n_state = srr_pkg::ST_IDLE;
                    end else if (i_out_free) begin
                        o_emit       = 1'b1;
                        o_res.action = srr_pkg::ACT_OPEN;
                        n_active     = 1'b1;
                        n_expected   = '0;
                        n_start_seq  = r_seq;
                        n_valid      = '0;
                        n_state      = srr_pkg::ST_EMIT2;
                    end
                end else if (r_type == srr_pkg::PKT_DATA) begin
                    if (w_off == '0) begin
                        // In order: deliver, then look at the next slot
                        if (i_out_free) begin
                            o_emit       = 1'b1;
                            o_res.action = srr_pkg::ACT_DELIVER;
                            o_res.handle = r_handle;
                            o_res.len    = r_len;
                            n_expected   = r_expected + srr_pkg::SEQ_W'(1);
                            if (r_valid[w_next_slot]) begin
                                o_ram.re    = 1'b1;
                                o_ram.raddr = w_next_slot;
                                n_state     = srr_pkg::ST_DRAIN;
                            end else begin
                                n_state = srr_pkg::ST_ACK;
                            end
                        end
                    end else if (w_off < w_win || r_seq < r_expected) begin
                        // Ahead in window: buffer once; stale: ack only
                        if (i_out_free) begin
                            if (w_off < w_win && !r_valid[w_slot]) begin
                                n_valid[w_slot] = 1'b1;
                                o_ram.we        = 1'b1;
                                o_ram.waddr     = w_slot;
                                o_ram.wdata     = {r_handle, r_len};
                            end
                            o_emit        = 1'b1;
                            o_res.ack_seq = r_seq;
                            o_res.last    = 1'b1;
                            n_state       = srr_pkg::ST_IDLE;
                        end
                    end else begin
                        n_state = srr_pkg::ST_IDLE;
                    end
                end else if (r_type == srr_pkg::PKT_END && r_seq == r_start_seq) begin
                    if (i_out_free) begin
                        o_emit        = 1'b1;
                        o_res.ack_seq = r_start_seq;
                        n_state       = srr_pkg::ST_EMIT2;
                    end
                end else begin
                    n_state = srr_pkg::ST_IDLE;
                end
            end

            srr_pkg::ST_EMIT2: begin
                // Ack after open, or close after the end ack
                if (i_out_free) begin
                    o_emit     = 1'b1;
                    o_res.last = 1'b1;
                    if (r_type == srr_pkg::PKT_START) begin
                        o_res.ack_seq = r_seq;
                    end else begin
                        o_res.action = srr_pkg::ACT_CLOSE;
                        n_active     = 1'b0;
                        n_conn_count = r_conn_count + srr_pkg::FILE_W'(1);
                    end
                    n_state = srr_pkg::ST_IDLE;
                end
            end

            srr_pkg::ST_DRAIN: begin
                // Deliver the slot held by the registered read, prefetch the next one
                if (i_out_free) begin
                    o_emit       = 1'b1;
                    o_res.action = srr_pkg::ACT_DELIVER;
                    o_res.handle = i_ram_rdata[srr_pkg::SLOT_W-1:srr_pkg::LEN_W];
                    o_res.len    = i_ram_rdata[srr_pkg::LEN_W-1:0];
                    n_valid[r_expected[srr_pkg::SLOT_AW-1:0]] = 1'b0;
                    n_expected   = r_expected + srr_pkg::SEQ_W'(1);
                    if (r_valid[w_drain_next]) begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = w_drain_next;
                    end else begin
                        n_state = srr_pkg::ST_ACK;
                    end
                end
            end

            srr_pkg::ST_ACK: begin
                if (i_out_free) begin
                    o_emit        = 1'b1;
                    o_res.ack_seq = r_seq;
                    o_res.last    = 1'b1;
                    n_state       = srr_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = srr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/selective_repeat_reorder_receiver.sv
`timescale 1ns / 1ps

// Selective-repeat receiver for one connection at a time. Each input item is
// a packet descriptor; each output item is one action (ack, deliver, open,
// close) with tlast on the final action caused by that packet. A bad or
// ignored packet gives nothing. An in-order data packet releases its buffered
// successors: the drain reads the slot memory one entry per cycle, while the
// output is free, through its single read port. The next packet is taken
// once the last result of the current one sits in the output register.
// Buffered slot contents live in a 32-entry memory indexed by the low
// sequence bits; slot valid bits are flops, so no clearing pass follows
// reset. window_size may be written only while the block is idle.
module selective_repeat_reorder_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [31:0] seq_num, [42:32] payload_len, [58:43] payload_handle, [63:59] zero
    input  logic [63:0] i_s_axis_tdata,
    // [1:0] pkt_type, [2] frame_good
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] ack_seq, [47:32] deliver_handle, [58:48] deliver_len,
    // [74:59] file_index, [79:75] zero
    output logic [79:0] o_m_axis_tdata,
    // [1:0] action
    output logic [1:0]  o_m_axis_tuser,
    // last_of_run
    output logic        o_m_axis_tlast
);

    logic [srr_pkg::WIN_W-1:0]  r_window;
    logic                       r_out_valid;
    srr_pkg::t_result           r_out;
    logic                       w_out_free;
    logic                       w_emit;
    srr_pkg::t_result           w_res;
    srr_pkg::t_ram_req          w_ram;
    logic [srr_pkg::SLOT_W-1:0] w_ram_rdata;

    // Window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= srr_pkg::WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_wdata;
        end
    end

    srr_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_s_axis_tvalid),
        .o_in_ready       (o_s_axis_tready),
        .i_pkt_type       (srr_pkg::t_pkt_type'(i_s_axis_tuser[1:0])),
        .i_seq_num        (i_s_axis_tdata[31:0]),
        .i_payload_len    (i_s_axis_tdata[42:32]),
        .i_payload_handle (i_s_axis_tdata[58:43]),
        .i_frame_good     (i_s_axis_tuser[2]),
        .i_window         (r_window),
        .i_out_free       (w_out_free),
        .o_emit           (w_emit),
        .o_res            (w_res),
        .o_ram            (w_ram),
        .i_ram_rdata      (w_ram_rdata)
    );

    srr_slot_ram #(
        .DEPTH (srr_pkg::WINDOW_MAX),
        .WIDTH (srr_pkg::SLOT_W)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_ram_rdata)
    );

    // Output register: load a new item when empty or being taken
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out.file_index, r_out.len, r_out.handle, r_out.ack_seq};
    assign o_m_axis_tuser  = r_out.action;
    assign o_m_axis_tlast  = r_out.last;

`ifndef ASSERT_OFF
    a_no_rw_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ram.we && w_ram.re))
        else $error("slot memory read and write in the same cycle");

    a_no_emit_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !w_emit)
        else $error("result produced while waiting for an input item");

    a_close_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_res.action == srr_pkg::ACT_CLOSE) |-> w_res.last)
        else $error("close action not marked last");

    a_open_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_res.action == srr_pkg::ACT_OPEN) |-> !w_res.last)
        else $error("open action marked last");
`endif

endmodule
